// File: design/edd_pkg.sv
// Shared types, register indexes and diffusion kernel tables for the dither block.
`timescale 1ns / 1ps

package edd_pkg;

    // Configuration register indexes (byte address is 4 * index).
    localparam logic [2:0] REG_RED_LEVELS   = 3'd0;
    localparam logic [2:0] REG_GREEN_LEVELS = 3'd1;
    localparam logic [2:0] REG_BLUE_LEVELS  = 3'd2;
    localparam logic [2:0] REG_KERNEL       = 3'd3;
    localparam logic [2:0] REG_GRAY_MODE    = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;

    // Kernel select codes.
    localparam logic [2:0] KERN_FS       = 3'd0;
    localparam logic [2:0] KERN_BURKES   = 3'd1;
    localparam logic [2:0] KERN_STUCKI   = 3'd2;
    localparam logic [2:0] KERN_SIERRA   = 3'd3;
    localparam logic [2:0] KERN_ATKINSON = 3'd4;

    typedef enum logic [2:0] {
        DEN_NONE,
        DEN_8,
        DEN_16,
        DEN_32,
        DEN_42
    } den_t;

    typedef logic [3:0] tap_num_t;

    // Numerators indexed [dy][dx + 2].
    localparam tap_num_t FS_NUM [3][5] = '{
        '{4'd0, 4'd0, 4'd0, 4'd7, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd1, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0}};
    localparam tap_num_t BURKES_NUM [3][5] = '{
        '{4'd0, 4'd0, 4'd0, 4'd8, 4'd4},
        '{4'd2, 4'd4, 4'd8, 4'd4, 4'd2},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0}};
    localparam tap_num_t STUCKI_NUM [3][5] = '{
        '{4'd0, 4'd0, 4'd0, 4'd8, 4'd4},
        '{4'd2, 4'd4, 4'd8, 4'd4, 4'd2},
        '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1}};
    localparam tap_num_t SIERRA_NUM [3][5] = '{
        '{4'd0, 4'd0, 4'd0, 4'd5, 4'd3},
        '{4'd2, 4'd4, 4'd5, 4'd4, 4'd2},
        '{4'd0, 4'd2, 4'd3, 4'd2, 4'd0}};
    localparam tap_num_t ATKINSON_NUM [3][5] = '{
        '{4'd0, 4'd0, 4'd0, 4'd1, 4'd1},
        '{4'd0, 4'd1, 4'd1, 4'd1, 4'd0},
        '{4'd0, 4'd0, 4'd1, 4'd0, 4'd0}};

    function automatic tap_num_t tap_num(input logic [2:0] kern, input logic [1:0] dy,
                                         input logic [2:0] dxi);
        tap_num_t num;
        case (kern)
            KERN_FS:       num = FS_NUM[dy][dxi];
            KERN_BURKES:   num = BURKES_NUM[dy][dxi];
            KERN_STUCKI:   num = STUCKI_NUM[dy][dxi];
            KERN_SIERRA:   num = SIERRA_NUM[dy][dxi];
            KERN_ATKINSON: num = ATKINSON_NUM[dy][dxi];
            default:       num = 4'd0;
        endcase
        return num;
    endfunction

    function automatic den_t tap_den(input logic [2:0] kern);
        den_t den;
        case (kern)
            KERN_FS:       den = DEN_16;
            KERN_BURKES:   den = DEN_32;
            KERN_STUCKI:   den = DEN_42;
            KERN_SIERRA:   den = DEN_32;
            KERN_ATKINSON: den = DEN_8;
            default:       den = DEN_NONE;
        endcase
        return den;
    endfunction

endpackage

// File: design/edd_if.sv
// Pixel stream interfaces: input pixel words and dithered output words.
`timescale 1ns / 1ps

interface edd_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;

    modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface edd_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: design/edd_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module edd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/edd_quant.sv
// Per-channel quantizer: level by reciprocal multiply, output by a bit-serial divider.
`timescale 1ns / 1ps

module edd_quant (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [7:0]        value,
    input  logic [7:0]        levels_m1,
    output logic              done,
    output logic [7:0]        quant,
    output logic signed [8:0] err
);

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_MUL,
        Q_LVL,
        Q_DIV,
        Q_DONE
    } qstate_t;

    qstate_t     state_reg;
    logic [7:0]  v_reg;
    logic [7:0]  d_reg;
    logic [15:0] p_reg;
    logic [15:0] num_reg;
    logic [7:0]  rem_reg;
    logic [3:0]  cnt_reg;

    logic [16:0] y;
    logic [24:0] t;
    logic [7:0]  est;
    logic [16:0] resid;
    logic [7:0]  level;
    logic [15:0] scaled;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        ge;
    logic [7:0]  rem_next;

    // round(v * (n-1) / 255): floor((2p + 255) / 510) = floor((p + 127) / 255)
    always_comb
    begin
        y      = {1'b0, p_reg} + 17'd127;
        t      = {8'b0, y} + {y, 8'b0};
        est    = t[23:16];
        resid  = y - {1'b0, est, 8'b0} + {9'b0, est};
        level  = (resid >= 17'd255) ? est + 8'd1 : est;
        scaled = {level, 8'b0} - {8'b0, level};
        trial  = {rem_reg, num_reg[15]};
        diff   = trial - {1'b0, d_reg};
        ge     = (trial >= {1'b0, d_reg});
        rem_next = ge ? diff[7:0] : trial[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                Q_IDLE:
                begin
                    if (start)
                    begin
                        v_reg     <= value;
                        d_reg     <= levels_m1;
                        state_reg <= Q_MUL;
                    end
                end
                Q_MUL:
                begin
                    p_reg     <= v_reg * d_reg;
                    state_reg <= Q_LVL;
                end
                Q_LVL:
                begin
                    num_reg   <= scaled;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= Q_DIV;
                end
                Q_DIV:
                begin
                    // shift the quotient bit into the dividend register
                    num_reg <= {num_reg[14:0], ge};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= Q_DONE;
                    end
                end
                Q_DONE:
                begin
                    state_reg <= Q_IDLE;
                end
                default:
                begin
                    state_reg <= Q_IDLE;
                end
            endcase
        end
    end

    assign done  = (state_reg == Q_DONE);
    assign quant = num_reg[7:0];
    assign err   = $signed({1'b0, v_reg}) - $signed({1'b0, num_reg[7:0]});

endmodule

// File: design/error_diffusion_dither.sv
// Top level of the error diffusion dither: control sequencer, error memory, APB registers.
`timescale 1ns / 1ps

// Error diffusion dither for an RGB pixel stream in raster order.
// Channels: pix_in takes one pixel word per valid/ready handshake, frame_start
// marks the first pixel of a frame. pix_out gives one dithered word per input
// word, in order. The APB port holds the level counts, kernel, gray mode and
// image size; write it only while the block is idle.
// Processing: one pixel at a time, through the 16-step quotient loop of the
// quantizer and five column visits on the single error memory, each a
// read-modify-write unless the column falls outside the image at a row edge;
// the memory holds all three error rows of all three channels side by side at
// each column address.
// A word with frame_start set first sweeps all MAX_WIDTH error memory
// addresses to zero, then runs as usual.
// Reset: registers take their defaults and all MAX_WIDTH addresses of the error
// memory are swept to zero with pix_in.ready low; APB writes are taken as ever.
// Stall: a finished word waits in the output register; the next pixel is
// accepted meanwhile and held at its end until the output register frees up.
module error_diffusion_dither #(
    parameter int MAX_WIDTH     = 2048,
    parameter int ERR_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    edd_pix_in_if.sink           pix_in,
    edd_pix_out_if.source        pix_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import edd_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int EW  = ERR_FRAC_BITS + 10;
    localparam int WW  = 9 * EW;
    localparam int FB  = ERR_FRAC_BITS;

    localparam longint LIM = (longint'(1) << (ERR_FRAC_BITS + 9)) - 1;
    localparam logic signed [EW:0] SAT_HI = (EW + 1)'(LIM);
    localparam logic signed [EW:0] SAT_LO = -SAT_HI;
    localparam logic signed [EW:0] HALF   = (EW + 1)'(1 << (ERR_FRAC_BITS - 1));

    localparam logic [FB-1:0] W42_1 = FB'(((1 << ERR_FRAC_BITS) + 21) / 42);
    localparam logic [FB-1:0] W42_2 = FB'(((2 << ERR_FRAC_BITS) + 21) / 42);
    localparam logic [FB-1:0] W42_4 = FB'(((4 << ERR_FRAC_BITS) + 21) / 42);
    localparam logic [FB-1:0] W42_8 = FB'(((8 << ERR_FRAC_BITS) + 21) / 42);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_VAL,
        S_QNT,
        S_CRD,
        S_CWR,
        S_POST
    } state_t;

    // One memory word per column: [row slot][channel] error values.
    typedef logic [2:0][2:0][EW-1:0] err_word_t;

    function automatic logic [FB-1:0] tap_weight(input logic [2:0] kern,
                                                 input logic [1:0] dy,
                                                 input logic [2:0] dxi);
        tap_num_t      num;
        logic [FB-1:0] wide;
        logic [FB-1:0] w;
        num  = tap_num(kern, dy, dxi);
        wide = {{(FB - 4){1'b0}}, num};
        case (tap_den(kern))
            DEN_8:  w = wide << (FB - 3);
            DEN_16: w = wide << (FB - 4);
            DEN_32: w = wide << (FB - 5);
            DEN_42:
            begin
                case (num)
                    4'd1:    w = W42_1;
                    4'd2:    w = W42_2;
                    4'd4:    w = W42_4;
                    4'd8:    w = W42_8;
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] d);
        logic [2:0] sum;
        sum = {1'b0, s} + {1'b0, d};
        return (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
    endfunction

    // configuration
    logic [8:0]  red_levels_reg, green_levels_reg, blue_levels_reg;
    logic [2:0]  kernel_reg;
    logic        gray_reg;
    logic [11:0] width_reg;
    logic [15:0] height_reg;

    // control
    state_t                state_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic                  pend_reg;
    logic [AW-1:0]         col_reg;
    logic [15:0]           row_reg;
    logic [1:0]            slot_reg;
    logic [2:0]            dxi_reg;
    logic [2:0][7:0]       px_reg;
    logic [2:0][7:0]       q_reg;
    logic signed [8:0]     e_reg [3];
    logic signed [EW-1:0]  prod_reg [3][3];
    logic                  out_valid_reg;
    logic [2:0][7:0]       out_reg;

    // datapath
    logic [AW:0]           weff;
    logic [11:0]           w0;
    logic [15:0]           h0;
    logic [AW-1:0]         col_next;
    logic [15:0]           row_next;
    logic [1:0]            slot_next;
    logic [AW-1:0]         col_post_next;
    logic [15:0]           row_post_next;
    logic [1:0]            slot_post_next;
    logic [AW+1:0]         xt;
    logic [AW+1:0]         xm2;
    logic                  x_ok;
    logic [AW-1:0]         x_addr;
    err_word_t             rd_word;
    err_word_t             wr_word;
    logic [7:0]            v_clamp [3];
    logic [7:0]            nm1 [3];
    logic signed [EW-1:0]  prod_next [3][3];
    logic                  chan_on [3];
    logic                  q_done [3];
    logic [7:0]            q_quant [3];
    logic signed [8:0]     q_err [3];
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [WW-1:0]         ram_wdata, ram_rdata;
    logic                  cfg_write;
    logic                  out_fire;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_levels_reg   <= 9'd2;
            green_levels_reg <= 9'd2;
            blue_levels_reg  <= 9'd2;
            kernel_reg       <= KERN_FS;
            gray_reg         <= 1'b0;
            width_reg        <= 12'd2048;
            height_reg       <= 16'd2048;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_RED_LEVELS:   red_levels_reg   <= pwdata[8:0];
                REG_GREEN_LEVELS: green_levels_reg <= pwdata[8:0];
                REG_BLUE_LEVELS:  blue_levels_reg  <= pwdata[8:0];
                REG_KERNEL:       kernel_reg       <= pwdata[2:0];
                REG_GRAY_MODE:    gray_reg         <= pwdata[0];
                REG_IMAGE_WIDTH:  width_reg        <= pwdata[11:0];
                REG_IMAGE_HEIGHT: height_reg       <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_RED_LEVELS:   prdata = {23'b0, red_levels_reg};
            REG_GREEN_LEVELS: prdata = {23'b0, green_levels_reg};
            REG_BLUE_LEVELS:  prdata = {23'b0, blue_levels_reg};
            REG_KERNEL:       prdata = {29'b0, kernel_reg};
            REG_GRAY_MODE:    prdata = {31'b0, gray_reg};
            REG_IMAGE_WIDTH:  prdata = {20'b0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {16'b0, height_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- effective sizes and levels ----------------
    function automatic logic [7:0] levels_m1(input logic [8:0] n);
        logic [8:0] m;
        m = n - 9'd1;
        if (n < 9'd2)
        begin
            return 8'd1;
        end
        if (n > 9'd256)
        begin
            return 8'd255;
        end
        return m[7:0];
    endfunction

    always_comb
    begin
        w0   = (width_reg == 12'd0) ? 12'd1 : width_reg;
        weff = (w0 > MAX_WIDTH) ? (AW + 1)'(MAX_WIDTH) : (AW + 1)'(w0);
        h0   = (height_reg == 16'd0) ? 16'd1 : height_reg;
        nm1[0] = levels_m1(red_levels_reg);
        nm1[1] = levels_m1(green_levels_reg);
        nm1[2] = levels_m1(blue_levels_reg);
        chan_on[0] = 1'b1;
        chan_on[1] = !gray_reg;
        chan_on[2] = !gray_reg;
    end

    // ---------------- position update ----------------
    // Before the pixel: restart on frame start, advance a row if the column
    // ran past a narrowed width, wrap the row at the height.
    always_comb
    begin
        logic [AW-1:0] c0;
        logic [16:0]   r0;
        logic [1:0]    s0;
        c0 = pix_in.frame_start ? '0 : col_reg;
        r0 = pix_in.frame_start ? '0 : {1'b0, row_reg};
        s0 = pix_in.frame_start ? '0 : slot_reg;
        if ({1'b0, c0} >= weff)
        begin
            c0 = '0;
            r0 = r0 + 17'd1;
            s0 = slot_add(s0, 2'd1);
        end
        if (r0 >= {1'b0, h0})
        begin
            r0 = '0;
        end
        col_next  = c0;
        row_next  = r0[15:0];
        slot_next = s0;
    end

    // After the pixel: step the column, roll over at the row end.
    always_comb
    begin
        logic [AW:0] c2;
        logic [16:0] r2;
        c2 = {1'b0, col_reg} + (AW + 1)'(1);
        r2 = {1'b0, row_reg} + 17'd1;
        col_post_next  = c2[AW-1:0];
        row_post_next  = row_reg;
        slot_post_next = slot_reg;
        if (c2 >= weff)
        begin
            col_post_next  = '0;
            slot_post_next = slot_add(slot_reg, 2'd1);
            row_post_next  = (r2 >= {1'b0, h0}) ? 16'd0 : r2[15:0];
        end
    end

    // ---------------- error datapath ----------------
    assign rd_word = err_word_t'(ram_rdata);

    always_comb
    begin
        xt     = {2'b0, col_reg} + {{(AW - 1){1'b0}}, dxi_reg};
        xm2    = xt - (AW + 2)'(2);
        x_ok   = (xt >= (AW + 2)'(2)) && (xm2 < {1'b0, weff});
        x_addr = xm2[AW-1:0];
    end

    // Own error: add it rounded half up, clamp to pixel range.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic signed [EW:0]   rsum;
            logic signed [EW:0]   rsh;
            logic signed [11:0]   vs;
            rsum = $signed({rd_word[slot_reg][ch][EW-1], rd_word[slot_reg][ch]}) + HALF;
            rsh  = rsum >>> FB;
            vs   = $signed({4'b0, px_reg[ch]}) + $signed(rsh[11:0]);
            if (vs < 12'sd0)
            begin
                v_clamp[ch] = 8'd0;
            end
            else if (vs > 12'sd255)
            begin
                v_clamp[ch] = 8'd255;
            end
            else
            begin
                v_clamp[ch] = vs[7:0];
            end
        end
    end

    // Weighted errors for the column at hand, one per channel and row offset;
    // zero where the target row lies below the frame or the channel is off.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int dy = 0; dy < 3; dy++)
            begin
                logic [FB-1:0] w;
                logic [16:0]   ty;
                w  = tap_weight(kernel_reg, 2'(dy), dxi_reg);
                ty = {1'b0, row_reg} + 17'(dy);
                if (chan_on[ch] && (ty < {1'b0, h0}))
                begin
                    prod_next[ch][dy] = $signed({{(EW - FB){1'b0}}, w})
                                      * $signed({{(EW - 9){e_reg[ch][8]}}, e_reg[ch]});
                end
                else
                begin
                    prod_next[ch][dy] = '0;
                end
            end
        end
    end

    // Modify the column word: clear the own entry on the center column, then
    // add each row's weighted error with saturation.
    always_comb
    begin
        wr_word = rd_word;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (chan_on[ch] && (dxi_reg == 3'd2))
            begin
                wr_word[slot_reg][ch] = '0;
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int dy = 0; dy < 3; dy++)
            begin
                logic [1:0]         sl;
                logic signed [EW:0] sum;
                sl  = slot_add(slot_reg, 2'(dy));
                sum = $signed({wr_word[sl][ch][EW-1], wr_word[sl][ch]})
                    + $signed({prod_reg[ch][dy][EW-1], prod_reg[ch][dy]});
                if (sum > SAT_HI)
                begin
                    wr_word[sl][ch] = SAT_HI[EW-1:0];
                end
                else if (sum < SAT_LO)
                begin
                    wr_word[sl][ch] = SAT_LO[EW-1:0];
                end
                else
                begin
                    wr_word[sl][ch] = sum[EW-1:0];
                end
            end
        end
    end

    // ---------------- memory control ----------------
    always_comb
    begin
        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_CWR);
        ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : x_addr;
        ram_wdata = (state_reg == S_CLEAR) ? '0 : WW'(wr_word);
        ram_re    = (state_reg == S_RD0) || ((state_reg == S_CRD) && x_ok);
        ram_raddr = (state_reg == S_RD0) ? col_reg : x_addr;
    end

    edd_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_WIDTH)
    ) u_err_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- quantizers ----------------
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_quant
        edd_quant u_quant (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (state_reg == S_VAL),
            .value     (v_clamp[ch]),
            .levels_m1 (nm1[ch]),
            .done      (q_done[ch]),
            .quant     (q_quant[ch]),
            .err       (q_err[ch])
        );
    end

    // ---------------- sequencer ----------------
    assign pix_in.ready = (state_reg == S_IDLE);
    assign out_fire     = out_valid_reg & pix_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            dxi_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the delivered word unless a new one is loaded below
            if (out_fire && (state_reg != S_POST))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(MAX_WIDTH - 1))
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= pend_reg ? S_RD0 : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pix_in.valid)
                    begin
                        px_reg[0] <= pix_in.red_in;
                        px_reg[1] <= pix_in.green_in;
                        px_reg[2] <= pix_in.blue_in;
                        col_reg   <= col_next;
                        row_reg   <= row_next;
                        slot_reg  <= slot_next;
                        if (pix_in.frame_start)
                        begin
                            clr_addr_reg <= '0;
                            pend_reg     <= 1'b1;
                            state_reg    <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_RD0;
                        end
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_VAL;
                end
                S_VAL:
                begin
                    state_reg <= S_QNT;
                end
                S_QNT:
                begin
                    if (q_done[0])
                    begin
                        for (int ch = 0; ch < 3; ch++)
                        begin
                            e_reg[ch] <= q_err[ch];
                            q_reg[ch] <= q_quant[ch];
                        end
                        dxi_reg   <= '0;
                        state_reg <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    // issue the column read and register the products together
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        for (int dy = 0; dy < 3; dy++)
                        begin
                            prod_reg[ch][dy] <= prod_next[ch][dy];
                        end
                    end
                    if (x_ok)
                    begin
                        state_reg <= S_CWR;
                    end
                    else if (dxi_reg == 3'd4)
                    begin
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        dxi_reg <= dxi_reg + 3'd1;
                    end
                end
                S_CWR:
                begin
                    if (dxi_reg == 3'd4)
                    begin
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        dxi_reg   <= dxi_reg + 3'd1;
                        state_reg <= S_CRD;
                    end
                end
                S_POST:
                begin
                    // hold here until the output register is free
                    if (!out_valid_reg || pix_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg[0]    <= q_reg[0];
                        out_reg[1]    <= gray_reg ? q_reg[0] : q_reg[1];
                        out_reg[2]    <= gray_reg ? q_reg[0] : q_reg[2];
                        col_reg       <= col_post_next;
                        row_reg       <= row_post_next;
                        slot_reg      <= slot_post_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_reg[0];
    assign pix_out.green_out = out_reg[1];
    assign pix_out.blue_out  = out_reg[2];

endmodule

// File: design/edd_checker.sv
// Port-level checker for the dither block and its bind to the top level.
`timescale 1ns / 1ps

module edd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign in_acc  = in_valid & in_ready;
    assign out_acc = out_valid & out_ready;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken again right after a pixel");

    a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 2'd0)
        else $error("output word without an accepted pixel");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two pixels in flight");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready)
);
